// File: src/tlvec_pkg.sv
// ----------------------------------------------------------------------------
// tlvec_pkg: shared types and constants of the TLV envelope checker
// Holds the payload structs of both channels, the register indexes, the fault
// codes and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tlvec_pkg;

   // Width of the name registers and the number of bytes they hold.
   localparam int NAME_REG_WIDTH = 48;
   localparam int NAME_REG_BYTES = NAME_REG_WIDTH / 8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NAME_TAG_TYPE = 2'd0;
   localparam logic [1:0] CSR_DATA_TAG_TYPE = 2'd1;
   localparam logic [1:0] CSR_RESPONSE_NAME = 2'd2;
   localparam logic [1:0] CSR_EVENT_NAME    = 2'd3;

   // Fault codes, lower value wins when several checks fail.
   localparam logic [2:0] FAULT_NONE          = 3'd0;
   localparam logic [2:0] FAULT_SHORT         = 3'd1;
   localparam logic [2:0] FAULT_NAME_TYPE     = 3'd2;
   localparam logic [2:0] FAULT_DATA_TYPE     = 3'd3;
   localparam logic [2:0] FAULT_NAME_LENGTH   = 3'd4;
   localparam logic [2:0] FAULT_NAME_MISMATCH = 3'd5;
   localparam logic [2:0] FAULT_EMPTY_BODY    = 3'd6;
   localparam logic [2:0] FAULT_OVERRUN       = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [7:0]                NAME_TAG_TYPE_RESET = 8'h01;
   localparam logic [7:0]                DATA_TAG_TYPE_RESET = 8'h02;
   localparam logic [NAME_REG_WIDTH-1:0] RESPONSE_NAME_RESET = 48'h7073_5250_4352;
   localparam logic [NAME_REG_WIDTH-1:0] EVENT_NAME_RESET    = 48'h7476_4550_4352;

   // One byte of the frame.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // Verdict on one frame.
   typedef struct packed {
      logic        accepted;
      logic [2:0]  fault_code;
      logic [15:0] body_length;
   } rsp_payload_type;

endpackage

// File: src/tlv_envelope_checker_core.sv
// ----------------------------------------------------------------------------
// tlv_envelope_checker_core: two-tag TLV envelope checker
// The verdict is registered and shown in the cycle after the final byte is taken.
// Throughput: one byte per cycle; the frame state and the result register
// are updated in the cycle a byte is taken, so bytes follow back to back.
// The input stalls only while a verdict waits on the result channel.
// Reset: synchronous, active high; clears the frame state and the result
// valid flag, and loads the register reset values.
// ----------------------------------------------------------------------------
module tlv_envelope_checker_core #(
   parameter int NAME_BYTES = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tlvec_pkg::req_payload_type    req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tlvec_pkg::rsp_payload_type    rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [tlvec_pkg::NAME_REG_WIDTH-1:0] csr_write_data
);

   // Frame layout positions derived from the name length.
   localparam logic [15:0] NAME_LEN      = 16'(NAME_BYTES);
   localparam logic [15:0] OVERHEAD      = 16'(6 + NAME_BYTES);
   localparam logic [15:0] POS_NAME_END  = 16'(3 + NAME_BYTES);
   localparam logic [15:0] POS_BODY_LOW  = 16'(4 + NAME_BYTES);
   localparam logic [15:0] POS_BODY_HIGH = 16'(5 + NAME_BYTES);

   // Keep the lower fault code.
   function automatic logic [2:0] note_fault(input logic [2:0] cur, input logic [2:0] code);
      if (cur == tlvec_pkg::FAULT_NONE || code < cur) begin
         return code;
      end
      return cur;
   endfunction

   // Configuration registers.
   logic [7:0]                          name_tag_type_ff;
   logic [7:0]                          data_tag_type_ff;
   logic [tlvec_pkg::NAME_REG_WIDTH-1:0] response_name_ff;
   logic [tlvec_pkg::NAME_REG_WIDTH-1:0] event_name_ff;

   // Frame state.
   logic [15:0] byte_position_ff, byte_position_in;
   logic [2:0]  first_fault_ff, first_fault_in;
   logic [15:0] name_length_ff, name_length_in;
   logic [15:0] body_length_ff, body_length_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   tlvec_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        req_transfer;
   logic [15:0] frame_len;
   logic [2:0]  byte_fault;
   logic [2:0]  final_fault;
   logic [16:0] body_plus_overhead;
   logic [2:0]  name_idx;
   logic [63:0] response_wide;
   logic [63:0] event_wide;
   logic [7:0]  response_byte;
   logic [7:0]  event_byte;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_payload_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         name_tag_type_ff <= tlvec_pkg::NAME_TAG_TYPE_RESET;
         data_tag_type_ff <= tlvec_pkg::DATA_TAG_TYPE_RESET;
         response_name_ff <= tlvec_pkg::RESPONSE_NAME_RESET;
         event_name_ff    <= tlvec_pkg::EVENT_NAME_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tlvec_pkg::CSR_NAME_TAG_TYPE: name_tag_type_ff <= csr_write_data[7:0];
            tlvec_pkg::CSR_DATA_TAG_TYPE: data_tag_type_ff <= csr_write_data[7:0];
            tlvec_pkg::CSR_RESPONSE_NAME: response_name_ff <= csr_write_data;
            tlvec_pkg::CSR_EVENT_NAME:    event_name_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Expected name bytes; positions past the registers expect zero.
   assign response_wide = {16'h0000, response_name_ff};
   assign event_wide    = {16'h0000, event_name_ff};
   assign name_idx      = 3'(byte_position_ff - 16'd3);
   assign response_byte = response_wide[8*name_idx +: 8];
   assign event_byte    = event_wide[8*name_idx +: 8];

   // Per-byte checks and length capture by frame position.
   always_comb begin
      byte_fault     = first_fault_ff;
      name_length_in = name_length_ff;
      body_length_in = body_length_ff;
      priority if (byte_position_ff == 16'd0) begin
         if (req_payload.data_byte != name_tag_type_ff) begin
            byte_fault = note_fault(first_fault_ff, tlvec_pkg::FAULT_NAME_TYPE);
         end
      end else if (byte_position_ff == 16'd1) begin
         name_length_in = {name_length_ff[15:8], req_payload.data_byte};
      end else if (byte_position_ff == 16'd2) begin
         name_length_in = {req_payload.data_byte, name_length_ff[7:0]};
      end else if (byte_position_ff < POS_NAME_END) begin
         if (req_payload.data_byte != response_byte && req_payload.data_byte != event_byte) begin
            byte_fault = note_fault(first_fault_ff, tlvec_pkg::FAULT_NAME_MISMATCH);
         end
      end else if (byte_position_ff == POS_NAME_END) begin
         if (req_payload.data_byte != data_tag_type_ff) begin
            byte_fault = note_fault(first_fault_ff, tlvec_pkg::FAULT_DATA_TYPE);
         end
      end else if (byte_position_ff == POS_BODY_LOW) begin
         body_length_in = {body_length_ff[15:8], req_payload.data_byte};
      end else if (byte_position_ff == POS_BODY_HIGH) begin
         body_length_in = {req_payload.data_byte, body_length_ff[7:0]};
      end else begin
         // Body bytes carry no check.
         byte_fault = first_fault_ff;
      end
   end

   // Frame length so far, saturating at the top of the counter.
   assign frame_len = (byte_position_ff == 16'hFFFF) ? byte_position_ff
                                                     : byte_position_ff + 16'd1;
   assign body_plus_overhead = {1'b0, body_length_in} + {1'b0, OVERHEAD};

   // End-of-frame checks.
   always_comb begin
      final_fault = byte_fault;
      if (frame_len < OVERHEAD) begin
         final_fault = note_fault(final_fault, tlvec_pkg::FAULT_SHORT);
      end
      if (name_length_in != NAME_LEN) begin
         final_fault = note_fault(final_fault, tlvec_pkg::FAULT_NAME_LENGTH);
      end
      if (final_fault == tlvec_pkg::FAULT_NONE) begin
         if (body_length_in == 16'd0) begin
            final_fault = tlvec_pkg::FAULT_EMPTY_BODY;
         end else if (body_plus_overhead > {1'b0, frame_len}) begin
            final_fault = tlvec_pkg::FAULT_OVERRUN;
         end
      end
   end

   // Next frame state and result.
   always_comb begin
      byte_position_in = byte_position_ff;
      first_fault_in   = first_fault_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_payload_in   = rsp_payload_ff;
      if (req_transfer) begin
         if (req_payload.last_byte) begin
            byte_position_in           = 16'd0;
            first_fault_in             = tlvec_pkg::FAULT_NONE;
            rsp_valid_in               = 1'b1;
            rsp_payload_in.accepted    = (final_fault == tlvec_pkg::FAULT_NONE);
            rsp_payload_in.fault_code  = final_fault;
            rsp_payload_in.body_length = (final_fault == tlvec_pkg::FAULT_NONE)
                                         ? body_length_in : 16'd0;
         end else begin
            byte_position_in = frame_len;
            first_fault_in   = byte_fault;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 16'd0;
         first_fault_ff   <= tlvec_pkg::FAULT_NONE;
         name_length_ff   <= 16'd0;
         body_length_ff   <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         first_fault_ff   <= first_fault_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (req_transfer && req_payload.last_byte) begin
            name_length_ff <= 16'd0;
            body_length_ff <= 16'd0;
         end else if (req_transfer) begin
            name_length_ff <= name_length_in;
            body_length_ff <= body_length_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// File: src/tlvec_sva.sv
// ----------------------------------------------------------------------------
// tlvec_sva: port-level checks of the TLV envelope checker
// Watches both channels and checks verdict consistency and result timing.
// ----------------------------------------------------------------------------
module tlvec_sva (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input tlvec_pkg::req_payload_type    req_payload,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input tlvec_pkg::rsp_payload_type    rsp_payload
);

   // A stalled verdict holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled verdict changed");

   // Accepted exactly when no fault is reported, and the body length is zero otherwise.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.accepted == (rsp_payload.fault_code == tlvec_pkg::FAULT_NONE))
                    && (rsp_payload.accepted || rsp_payload.body_length == 16'd0))
      else $error("verdict fields disagree");

   // A final byte transfer yields a verdict in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_byte |=> rsp_valid)
      else $error("missing verdict after final byte");

   // A non-final byte transfer never yields a verdict.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.last_byte |=> !rsp_valid)
      else $error("verdict without final byte");

endmodule

bind tlv_envelope_checker_core tlvec_sva u_tlvec_sva (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for the TLV envelope checker core
// Frames of bytes are streamed into the core and each verdict is checked
// against a verdict computed in the bench from the same bytes and register
// values. Directed frames hit every fault code and fault precedence.
// Random frames, mostly well formed, run under several configurations and
// several idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int NAME_BYTES     = 6;
   localparam int FRAME_OVERHEAD = 6 + NAME_BYTES;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BYTES_PER_PHASE = 45;

   // Clock, reset and the ports of the core; the driven inputs are known from time zero.
   logic                                 clock;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_ready;
   tlvec_pkg::req_payload_type           req_payload      = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready        = 1'b0;
   tlvec_pkg::rsp_payload_type           rsp_payload;
   logic                                 csr_write_enable = 1'b0;
   logic [1:0]                           csr_index        = tlvec_pkg::CSR_NAME_TAG_TYPE;
   logic [tlvec_pkg::NAME_REG_WIDTH-1:0] csr_write_data   = '0;

   // Register values as the bench believes them to be.
   logic [7:0] cfg_name_type = tlvec_pkg::NAME_TAG_TYPE_RESET;
   logic [7:0] cfg_data_type = tlvec_pkg::DATA_TAG_TYPE_RESET;
   logic [tlvec_pkg::NAME_REG_WIDTH-1:0] cfg_response_name = tlvec_pkg::RESPONSE_NAME_RESET;
   logic [tlvec_pkg::NAME_REG_WIDTH-1:0] cfg_event_name    = tlvec_pkg::EVENT_NAME_RESET;

   // Frame tracking state of the verdict predictor.
   logic [15:0] frame_pos      = '0;
   logic [2:0]  frame_fault    = tlvec_pkg::FAULT_NONE;
   logic [15:0] frame_name_len = '0;
   logic [15:0] frame_body_len = '0;

   tlvec_pkg::rsp_payload_type expected_verdicts[$];
   tlvec_pkg::rsp_payload_type oldest_verdict;
   logic [7:0]                 frame_bytes[$];

   int mismatch_count = 0;
   int bytes_sent     = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int holdoff_cycles = 0;
   int holdoff_seq    = 0;

   tlv_envelope_checker_core #(
      .NAME_BYTES (NAME_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Byte idx of a stored name; positions past the register read as zero.
   function automatic logic [7:0] stored_name_byte(
         input logic [tlvec_pkg::NAME_REG_WIDTH-1:0] name, input int idx);
      if (idx >= tlvec_pkg::NAME_REG_BYTES) return 8'h00;
      return name[8*idx +: 8];
   endfunction

   // Keep the lowest nonzero fault code of the frame.
   function automatic void note_fault(input logic [2:0] code);
      if (frame_fault == tlvec_pkg::FAULT_NONE || code < frame_fault) frame_fault = code;
   endfunction

   // Advance the frame state by one byte and queue a verdict on the final byte.
   function automatic void predict_byte(input tlvec_pkg::req_payload_type item);
      logic [15:0]                pos;
      logic [15:0]                len;
      int                         idx;
      tlvec_pkg::rsp_payload_type verdict;
      pos = frame_pos;
      if (pos == 16'd0) begin
         if (item.data_byte != cfg_name_type) note_fault(tlvec_pkg::FAULT_NAME_TYPE);
      end else if (pos == 16'd1) begin
         frame_name_len[7:0] = item.data_byte;
      end else if (pos == 16'd2) begin
         frame_name_len[15:8] = item.data_byte;
      end else if (int'(pos) < 3 + NAME_BYTES) begin
         idx = int'(pos) - 3;
         if (item.data_byte != stored_name_byte(cfg_response_name, idx) &&
             item.data_byte != stored_name_byte(cfg_event_name, idx))
            note_fault(tlvec_pkg::FAULT_NAME_MISMATCH);
      end else if (int'(pos) == 3 + NAME_BYTES) begin
         if (item.data_byte != cfg_data_type) note_fault(tlvec_pkg::FAULT_DATA_TYPE);
      end else if (int'(pos) == 4 + NAME_BYTES) begin
         frame_body_len[7:0] = item.data_byte;
      end else if (int'(pos) == 5 + NAME_BYTES) begin
         frame_body_len[15:8] = item.data_byte;
      end
      // The frame length stops counting at its maximum.
      len = (pos == 16'hFFFF) ? pos : pos + 16'd1;
      if (!item.last_byte) begin
         frame_pos = len;
         return;
      end
      if (int'(len) < FRAME_OVERHEAD) note_fault(tlvec_pkg::FAULT_SHORT);
      if (frame_name_len != 16'(NAME_BYTES)) note_fault(tlvec_pkg::FAULT_NAME_LENGTH);
      if (frame_fault == tlvec_pkg::FAULT_NONE) begin
         if (frame_body_len == 16'd0) note_fault(tlvec_pkg::FAULT_EMPTY_BODY);
         else if (int'(frame_body_len) + FRAME_OVERHEAD > int'(len))
            note_fault(tlvec_pkg::FAULT_OVERRUN);
      end
      verdict.accepted    = (frame_fault == tlvec_pkg::FAULT_NONE);
      verdict.fault_code  = frame_fault;
      verdict.body_length = (frame_fault == tlvec_pkg::FAULT_NONE) ? frame_body_len : 16'd0;
      expected_verdicts.push_back(verdict);
      frame_pos      = '0;
      frame_fault    = tlvec_pkg::FAULT_NONE;
      frame_name_len = '0;
      frame_body_len = '0;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Compare every verdict transfer with the oldest predicted verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("verdict with none outstanding", 16'(rsp_payload.fault_code), 16'd0);
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            if (rsp_payload.accepted !== oldest_verdict.accepted)
               report_mismatch("accepted", 16'(rsp_payload.accepted),
                               16'(oldest_verdict.accepted));
            if (rsp_payload.fault_code !== oldest_verdict.fault_code)
               report_mismatch("fault_code", 16'(rsp_payload.fault_code),
                               16'(oldest_verdict.fault_code));
            if (rsp_payload.body_length !== oldest_verdict.body_length)
               report_mismatch("body_length", rsp_payload.body_length,
                               oldest_verdict.body_length);
         end
      end
   end

   // The result side: random stalls, or a long hold-off when one is requested.
   initial begin : receiver
      int hold_left;
      int seen_seq;
      hold_left = 0;
      seen_seq  = 0;
      forever begin
         @(posedge clock);
         if (holdoff_seq != seen_seq) begin
            seen_seq  = holdoff_seq;
            hold_left = holdoff_cycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tlv_envelope_checker_core regression: fail");
         $finish;
      end
   end

   // Offer one byte after a random gap and predict once it is transferred.
   task automatic send_byte(input tlvec_pkg::req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(item);
      bytes_sent++;
   endtask

   task automatic send_frame();
      tlvec_pkg::req_payload_type item;
      foreach (frame_bytes[k]) begin
         item.data_byte = frame_bytes[k];
         item.last_byte = (k == frame_bytes.size() - 1);
         send_byte(item);
      end
   endtask

   // Stop offering bytes and wait until every verdict has come out.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles; upper bits of the type
   // registers carry whatever the caller passes and must be dropped.
   task automatic set_config(input logic [tlvec_pkg::NAME_REG_WIDTH-1:0] name_type_word,
                             input logic [tlvec_pkg::NAME_REG_WIDTH-1:0] data_type_word,
                             input logic [tlvec_pkg::NAME_REG_WIDTH-1:0] response_word,
                             input logic [tlvec_pkg::NAME_REG_WIDTH-1:0] event_word);
      csr_write_enable <= 1'b1;
      csr_index        <= tlvec_pkg::CSR_NAME_TAG_TYPE;
      csr_write_data   <= name_type_word;
      @(posedge clock);
      csr_index        <= tlvec_pkg::CSR_DATA_TAG_TYPE;
      csr_write_data   <= data_type_word;
      @(posedge clock);
      csr_index        <= tlvec_pkg::CSR_RESPONSE_NAME;
      csr_write_data   <= response_word;
      @(posedge clock);
      csr_index        <= tlvec_pkg::CSR_EVENT_NAME;
      csr_write_data   <= event_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_name_type     = name_type_word[7:0];
      cfg_data_type     = data_type_word[7:0];
      cfg_response_name = response_word;
      cfg_event_name    = event_word;
   endtask

   function automatic logic [tlvec_pkg::NAME_REG_WIDTH-1:0] random_word48();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[tlvec_pkg::NAME_REG_WIDTH-1:0];
   endfunction

   // Build a two-tag envelope; name_pick bit i takes the event name at byte i.
   task automatic build_frame(input logic [7:0] name_type, input logic [15:0] name_len,
                              input logic [NAME_BYTES-1:0] name_pick,
                              input logic [7:0] data_type, input logic [15:0] body_len,
                              input int body_count);
      frame_bytes.delete();
      frame_bytes.push_back(name_type);
      frame_bytes.push_back(name_len[7:0]);
      frame_bytes.push_back(name_len[15:8]);
      for (int i = 0; i < NAME_BYTES; i++)
         frame_bytes.push_back(name_pick[i] ? stored_name_byte(cfg_event_name, i)
                                            : stored_name_byte(cfg_response_name, i));
      frame_bytes.push_back(data_type);
      frame_bytes.push_back(body_len[7:0]);
      frame_bytes.push_back(body_len[15:8]);
      repeat (body_count) frame_bytes.push_back(8'($urandom));
   endtask

   // Mostly well-formed envelopes with random content, plus corrupted,
   // truncated and pure noise frames.
   task automatic build_random_frame();
      int          pick;
      int          body_count;
      int          spot;
      int          cut;
      logic [15:0] body_len;
      pick = $urandom_range(99);
      if (pick < 8) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
         return;
      end
      body_len   = 16'($urandom_range(1, 12));
      body_count = int'(body_len) + $urandom_range(0, 2);
      case ($urandom_range(9))
         0: body_len = 16'd0;
         1: body_count = int'(body_len) - 1;
         2: body_len = 16'($urandom);
         default: ;
      endcase
      build_frame(cfg_name_type, 16'(NAME_BYTES), NAME_BYTES'($urandom), cfg_data_type,
                  body_len, body_count);
      if (pick < 23) begin
         spot = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[spot] = 8'($urandom);
      end else if (pick < 31) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
   endtask

   // Every fault code and fault precedence at reset values.
   task automatic test_directed_frames();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // Good frames: response name, event name with trailing bytes, mixed name.
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd1, 1);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), '1, cfg_data_type, 16'd3, 5);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), 6'b101010, cfg_data_type, 16'd2, 2);
      send_frame();
      // Single-byte frame: short wins over the wrong type byte.
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      send_frame();
      // One byte below the overhead.
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd1, 0);
      void'(frame_bytes.pop_back());
      send_frame();
      // Wrong name type together with a wrong data type.
      build_frame(~cfg_name_type, 16'(NAME_BYTES), '1, ~cfg_data_type, 16'd1, 1);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, 8'hFF, 16'd1, 1);
      send_frame();
      // Bad name length, alone and with a name mismatch behind it.
      build_frame(cfg_name_type, 16'h0106, '0, cfg_data_type, 16'd1, 1);
      frame_bytes[3] = 8'h00;
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES - 1), '1, cfg_data_type, 16'd1, 1);
      send_frame();
      // Mismatch in the last name byte only.
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd1, 1);
      frame_bytes[2 + NAME_BYTES] = 8'h00;
      send_frame();
      // Empty body, short overrun and the largest body lengths.
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd0, 2);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), '1, cfg_data_type, 16'd4, 3);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'hFFFF, 0);
      send_frame();
      build_frame(cfg_name_type, 16'(NAME_BYTES), '1, cfg_data_type, 16'hFF00, 4);
      send_frame();
      wait_for_idle();
   endtask

   // Extreme register values, with junk above the type bytes.
   task automatic test_config_extremes();
      logic [tlvec_pkg::NAME_REG_WIDTH-1:0] junk;
      for (int setting = 0; setting < 3; setting++) begin
         junk = random_word48();
         case (setting)
            0: set_config({junk[47:8], 8'h00}, {junk[47:8], 8'hFF}, '0, '1);
            1: set_config({junk[47:8], 8'hFF}, {junk[47:8], 8'h00}, '1, '0);
            default: set_config({junk[47:8], 8'h5A}, {junk[47:8], 8'h5A}, junk, junk);
         endcase
         build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd1, 1);
         send_frame();
         build_frame(cfg_name_type, 16'(NAME_BYTES), NAME_BYTES'($urandom), cfg_data_type,
                     16'd2, 3);
         send_frame();
         build_frame(cfg_name_type, 16'(NAME_BYTES), '1, ~cfg_data_type, 16'd1, 1);
         send_frame();
         build_frame(cfg_name_type, 16'(NAME_BYTES), '0, cfg_data_type, 16'd3, 2);
         frame_bytes[3] = ~frame_bytes[3];
         send_frame();
         wait_for_idle();
      end
   endtask

   // Random frames in four idle patterns, each under a fresh configuration.
   task automatic test_random_frames();
      int                                   phase_start;
      logic [tlvec_pkg::NAME_REG_WIDTH-1:0] response_word;
      logic [tlvec_pkg::NAME_REG_WIDTH-1:0] name_type_word;
      logic [tlvec_pkg::NAME_REG_WIDTH-1:0] data_type_word;
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         name_type_word = random_word48();
         data_type_word = ($urandom_range(3) == 0) ? name_type_word : random_word48();
         response_word  = random_word48();
         set_config(name_type_word, data_type_word, response_word,
                    ($urandom_range(3) == 0) ? response_word : random_word48());
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE) begin
            build_random_frame();
            send_frame();
         end
      end
      wait_for_idle();
   endtask

   // Hold the result side off so the core fills up and stalls its input.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      holdoff_cycles = 300;
      holdoff_seq++;
      repeat (8) begin
         build_frame(cfg_name_type, 16'(NAME_BYTES), NAME_BYTES'($urandom), cfg_data_type,
                     16'd2, 2);
         send_frame();
         frame_bytes.delete();
         frame_bytes.push_back(8'($urandom));
         send_frame();
      end
      // The sender pauses here until every verdict has been taken.
      wait_for_idle();
      rsp_stall_pct = 50;
      repeat (4) begin
         build_random_frame();
         send_frame();
      end
      wait_for_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_for_idle();
      test_directed_frames();
      test_config_extremes();
      test_random_frames();
      test_backpressure();
      wait_for_idle();
      if (expected_verdicts.size() != 0)
         report_mismatch("verdicts left outstanding", 16'(expected_verdicts.size()), 16'd0);
      if (mismatch_count == 0) begin
         $display("tlv_envelope_checker_core regression: pass");
      end else begin
         $display("tlv_envelope_checker_core regression: fail");
      end
      $finish;
   end

endmodule
